// ===== hw/rtl/spw_pkg.sv =====
// Shared types and constants for the shadowed pixel write command stream.
// Used by the top level and spw_fmt; depends on nothing.
package spw_pkg;

   localparam int FRAME_BYTES = 1024;
   localparam int PAGE_WIDTH = 128;
   localparam int ADDR_W = $clog2(FRAME_BYTES);
   localparam int PAGE_W = 4;
   localparam int SUM_W = $clog2(FRAME_BYTES + (1 << PAGE_W) * PAGE_WIDTH + 256);

   localparam logic [7:0] CMD_PAGE = 8'hB0;
   localparam logic [7:0] CMD_COL_HI = 8'h10;
   localparam logic [3:0] CMD_COL_LO = 4'h0;

   typedef enum logic [1:0] {
      BEAT_PAGE,
      BEAT_COL_LO,
      BEAT_COL_HI,
      BEAT_DATA
   } beat_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [7:0]        column;
      logic [7:0]        data;
   } upd_type;

endpackage

// ===== hw/rtl/shadowed_pixel_write_command_stream_top.sv =====
// Top level: shadow frame memory, read-modify-write sequencer and byte output.
// Depends on spw_pkg, spw_ram and spw_fmt.
// A changed pixel's first byte is sent after the item passes ST_READ into ST_EMIT.
// req_stall holds new items off until a changed pixel has had its read, write-back
// and four output bytes, or an unchanged one its read; an ignored one is dropped.
// Reset clears control state and then sweeps the 1024-byte memory to zero, one byte
// a cycle, with req_stall high; csr writes are taken throughout.
module shadowed_pixel_write_command_stream_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_column_x,
   input  logic [6:0] req_row_y,
   input  logic       req_pixel_on,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_data,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [spw_pkg::ADDR_W-1:0]     clr_ff, clr_in;
   logic [spw_pkg::ADDR_W-1:0]     waddr_ff, waddr_in;
   logic [2:0]                     bit_ff, bit_in;
   logic                           on_ff, on_in;
   logic [spw_pkg::PAGE_W-1:0]     page_ff, page_in;
   logic [7:0]                     col_ff, col_in;
   logic [7:0]                     data_ff, data_in;
   spw_pkg::beat_type              beat_ff, beat_in;
   logic                           ready_ff, ready_in;

   logic                           req_accept;
   logic [spw_pkg::SUM_W-1:0]      addr_sum;
   logic                           in_range;
   logic                           ram_we;
   logic [spw_pkg::ADDR_W-1:0]     ram_waddr;
   logic [7:0]                     ram_wdata;
   logic [7:0]                     ram_rdata;
   logic [7:0]                     bit_mask;
   logic [7:0]                     new_byte;
   spw_pkg::upd_type               upd;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);

   assign addr_sum = spw_pkg::SUM_W'(req_row_y[6:3]) * spw_pkg::SUM_W'(spw_pkg::PAGE_WIDTH)
                     + spw_pkg::SUM_W'(req_column_x);
   assign in_range = addr_sum < spw_pkg::SUM_W'(spw_pkg::FRAME_BYTES);

   assign bit_mask = 8'h01 << bit_ff;
   assign new_byte = on_ff ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

   assign upd.page = page_ff;
   assign upd.column = col_ff;
   assign upd.data = data_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      waddr_in = waddr_ff;
      bit_in = bit_ff;
      on_in = on_ff;
      page_in = page_ff;
      col_in = col_ff;
      data_in = data_ff;
      beat_in = beat_ff;
      ready_in = csr_wr_en ? csr_wr_data : ready_ff;
      ram_we = 1'b0;
      ram_waddr = waddr_ff;
      ram_wdata = new_byte;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 8'h00;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == spw_pkg::ADDR_W'(spw_pkg::FRAME_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && ready_ff && in_range) begin
               state_in = ST_READ;
               waddr_in = addr_sum[spw_pkg::ADDR_W-1:0];
               bit_in = req_row_y[2:0];
               on_in = req_pixel_on;
               page_in = req_row_y[6:3];
               col_in = req_column_x;
            end
         end
         ST_READ: begin
            if (new_byte != ram_rdata) begin
               ram_we = 1'b1;
               data_in = new_byte;
               beat_in = spw_pkg::BEAT_PAGE;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (beat_ff == spw_pkg::BEAT_DATA) begin
                  state_in = ST_IDLE;
               end else begin
                  beat_in = spw_pkg::beat_type'(2'(beat_ff + 2'd1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         ready_ff <= 1'b0;
         beat_ff <= spw_pkg::BEAT_PAGE;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         ready_ff <= ready_in;
         beat_ff <= beat_in;
      end
      waddr_ff <= waddr_in;
      bit_ff <= bit_in;
      on_ff <= on_in;
      page_ff <= page_in;
      col_ff <= col_in;
      data_ff <= data_in;
   end

   spw_ram #(
      .DEPTH(spw_pkg::FRAME_BYTES),
      .WIDTH(8)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(addr_sum[spw_pkg::ADDR_W-1:0]),
      .rd_data(ram_rdata)
   );

   spw_fmt u_fmt (
      .upd      (upd),
      .beat     (beat_ff),
      .is_data  (rsp_is_data),
      .out_byte (rsp_out_byte),
      .last_byte(rsp_last_byte)
   );

endmodule

// ===== hw/rtl/spw_ram.sv =====
// Generic simple dual-port synchronous RAM with registered read data.
// One write port and one read port; depends on nothing.
module spw_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/spw_fmt.sv =====
// Builds one display byte of an update from the beat position.
// Depends on spw_pkg for the update struct, beat codes and command bytes.
module spw_fmt (
   input  spw_pkg::upd_type  upd,
   input  spw_pkg::beat_type beat,
   output logic              is_data,
   output logic [7:0]        out_byte,
   output logic              last_byte
);

   always_comb begin
      is_data = 1'b0;
      last_byte = 1'b0;
      unique case (beat)
         spw_pkg::BEAT_PAGE: begin
            out_byte = spw_pkg::CMD_PAGE | 8'(upd.page);
         end
         spw_pkg::BEAT_COL_LO: begin
            out_byte = {spw_pkg::CMD_COL_LO, upd.column[3:0]};
         end
         spw_pkg::BEAT_COL_HI: begin
            out_byte = spw_pkg::CMD_COL_HI | {4'h0, upd.column[7:4]};
         end
         spw_pkg::BEAT_DATA: begin
            out_byte = upd.data;
            is_data = 1'b1;
            last_byte = 1'b1;
         end
         default: begin
            out_byte = upd.data;
         end
      endcase
   end

endmodule

// ===== hw/rtl/spw_checker.sv =====
// Port-level checker for the shadowed pixel write command stream top level.
// Depends only on the top level's ports; attached by the bind at the end.
module spw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_data,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_is_data) && $stable(rsp_last_byte))
      else $error("Stalled output item changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_data == rsp_last_byte))
      else $error("Only the data byte may close an update.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("Input taken while an update is still being sent.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_byte |=> !rsp_valid)
      else $error("Output continued past the last byte of an update.");

   assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("Input accepted before the memory clearing pass.");

endmodule

bind shadowed_pixel_write_command_stream_top spw_checker u_spw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_is_data  (rsp_is_data),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last_byte(rsp_last_byte)
);
